@@ sv/cbce_pkg.sv @@
// ============================================================================
// cbce_pkg: shared types and constants of the collision bitmap clip engine
// Field widths, operation codes, sequencer states and the span mask helper.
// ============================================================================
`default_nettype none

package cbce_pkg;

  localparam int OP_W   = 3;
  localparam int X_W    = 9;
  localparam int ROW_W  = 8;
  localparam int VEL_W  = 8;
  localparam int ADDR_W = 13;
  localparam int BYTE_W = 8;

  // Width used for address arithmetic and range compares; covers the largest
  // map that the parameters allow.
  localparam int CALC_W = 20;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_SET_OBJ = 3'd1,
    OP_CLR_OBJ = 3'd2,
    OP_CLR_SCR = 3'd3,
    OP_TEST    = 3'd4,
    OP_CLIP_X  = 3'd5,
    OP_CLIP_Y  = 3'd6,
    OP_READ    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_BREAD,
    ST_BYTE,
    ST_ROW,
    ST_RD,
    ST_EV,
    ST_WR,
    ST_FIN
  } state_e;

  // Bits of byte column col covered by pixels x1..x2; both end masks apply
  // when the span starts and ends in the same byte.
  function automatic logic [BYTE_W-1:0] span_mask(input logic [5:0] col,
                                                  input logic [X_W-1:0] x1,
                                                  input logic [X_W-1:0] x2);
    logic [BYTE_W-1:0] m;
    m = 8'hff;
    if (col == x2[8:3]) begin
      m = m & (8'hff << (3'd7 - x2[2:0]));
    end
    if (col == x1[8:3]) begin
      m = m & (8'hff >> x1[2:0]);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ sv/cbce_in_if.sv @@
// ============================================================================
// cbce_in_if: request channel of the collision bitmap clip engine
// Valid/ready channel carrying one operation and its operands per beat.
// ============================================================================
`default_nettype none

interface cbce_in_if;
  import cbce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [X_W-1:0]           span_left;
  logic [X_W-1:0]           span_right;
  logic [ROW_W-1:0]         row;
  logic signed [VEL_W-1:0]  velocity;
  logic [ADDR_W-1:0]        byte_address;
  logic [BYTE_W-1:0]        byte_data;
  logic                     map_select;

  modport source (
    output valid, operation, span_left, span_right, row, velocity,
           byte_address, byte_data, map_select,
    input  ready
  );

  modport sink (
    input  valid, operation, span_left, span_right, row, velocity,
           byte_address, byte_data, map_select,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/cbce_out_if.sv @@
// ============================================================================
// cbce_out_if: result channel of the collision bitmap clip engine
// Valid/ready channel carrying one result per beat.
// ============================================================================
`default_nettype none

interface cbce_out_if;
  import cbce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]  allowed_move;
  logic                     pixel_set;
  logic [BYTE_W-1:0]        read_value;

  modport source (
    output valid, allowed_move, pixel_set, read_value,
    input  ready
  );

  modport sink (
    input  valid, allowed_move, pixel_set, read_value,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/cbce_ram.sv @@
// ============================================================================
// cbce_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module cbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/collision_bitmap_clip_engine.sv @@
// ============================================================================
// collision_bitmap_clip_engine: boundary bitmaps with span edits and clipping
// Screen and object maps held in two RAMs, worked on by a small sequencer.
// ============================================================================
// Use: each beat on in_i carries one operation; exactly one beat leaves on
// out_o for it, in order. One item is worked on at a time and in_i.ready is
// high only while the sequencer is idle.
// Sequence (from acceptance to the result standing in the output register,
// each ending in FIN): load LOAD; read BREAD, BYTE; pixel test ROW, RD, EV
// (ROW alone when the row is off the map); span set/clear ROW, then RD, EV,
// WR per byte column on the map and RD, EV per column off it; clip x ROW,
// then RD, EV per byte column scanned (stops at the first hit); clip y ROW
// per scanned row, plus RD, EV per byte column of every scanned row on the
// map (stops at the first hit). Every column costs one RAM read with
// registered data; a zero velocity clip goes straight to FIN.
// Reset: both maps are cleared by a pass over all LINE_BYTES*ROWS addresses,
// one byte of each map per cycle; in_i.ready stays low until it has finished.
// Stall: a finished result waits in the output register; the next item may
// be accepted meanwhile, and its own result waits until that register frees.
// ============================================================================
`default_nettype none

module collision_bitmap_clip_engine #(
  parameter int LINE_BYTES = 40,
  parameter int ROWS       = 200
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cbce_in_if.sink     in_i,
  cbce_out_if.source  out_o
);
  import cbce_pkg::*;

  localparam int MAP_BYTES = LINE_BYTES * ROWS;
  localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  function automatic logic [2:0] first_set(input logic [7:0] b);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        k = 3'(7 - i);
      end
    end
    return k;
  endfunction

  function automatic logic [2:0] last_set(input logic [7:0] b);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        k = 3'(7 - i);
      end
    end
    return k;
  endfunction

  // Sequencer and operand registers
  state_e                   state_q, state_d;
  op_e                      op_q, op_d;
  logic [X_W-1:0]           x1_q, x1_d, x2_q, x2_d;
  logic [ROW_W-1:0]         r_q, r_d;
  logic signed [VEL_W-1:0]  v_q, v_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic [BYTE_W-1:0]        data_q, data_d;
  logic                     sel_q, sel_d;
  logic                     dn_q, dn_d;
  logic signed [7:0]        c_q, c_d, c_start_q, c_start_d, c_end_q, c_end_d;
  logic signed [10:0]       lo_q, lo_d, hi_q, hi_d, half_q, half_d;
  logic signed [9:0]        j_q, j_d, jend_q, jend_d;
  logic [AW-1:0]            row_base_q, row_base_d;
  logic                     row_ok_q, row_ok_d;
  logic                     ok_q, ok_d;
  logic [BYTE_W-1:0]        wr_data_q, wr_data_d;
  logic signed [VEL_W-1:0]  res_move_q, res_move_d;
  logic                     res_pix_q, res_pix_d;
  logic [BYTE_W-1:0]        res_rd_q, res_rd_d;
  logic signed [VEL_W-1:0]  out_move_q, out_move_d;
  logic                     out_pix_q, out_pix_d;
  logic [BYTE_W-1:0]        out_rd_q, out_rd_d;
  logic                     out_valid_q, out_valid_d;
  logic [AW-1:0]            clr_q, clr_d;

  // RAM ports
  logic                     scr_we, obj_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]        ram_wdata, scr_rdata, obj_rdata;

  cbce_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_BYTES)) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (scr_rdata)
  );

  cbce_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_BYTES)) u_object_ram (
    .clk_i   (clk_i),
    .we_i    (obj_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (obj_rdata)
  );

  // Address generation
  logic [CALC_W-1:0] col_sum, addr_wide, row_prod;
  logic [AW-1:0]     col_addr, byte_raddr;
  logic              cell_ok, row_ok, addr_ok;

  assign col_sum    = CALC_W'(row_base_q) + CALC_W'(c_q[6:0]);
  assign col_addr   = col_sum[AW-1:0];
  assign addr_wide  = CALC_W'(addr_q);
  assign byte_raddr = addr_wide[AW-1:0];
  assign addr_ok    = addr_wide < CALC_W'(MAP_BYTES);
  assign row_prod   = CALC_W'(j_q[8:0]) * CALC_W'(LINE_BYTES);
  assign row_ok     = !j_q[9] && (CALC_W'(j_q[8:0]) < CALC_W'(ROWS));
  assign cell_ok    = row_ok_q && !c_q[7] && (CALC_W'(c_q[6:0]) < CALC_W'(LINE_BYTES));
  assign ram_raddr  = (state_q == ST_BREAD) ? byte_raddr : col_addr;

  // Evaluation of a fetched column
  logic [BYTE_W-1:0]   byte_or, mask, tgt_byte;
  logic [2:0]          k_sel;
  logic signed [10:0]  bpos, x1_ext, x2_ext, v_ext, front, mv_raw;
  logic signed [VEL_W-1:0] mv_sat;
  logic                bpos_in, rear, y_hit;
  logic signed [9:0]   step, y_move;

  assign byte_or  = ok_q ? (scr_rdata | obj_rdata) : '0;
  assign k_sel    = dn_q ? last_set(byte_or) : first_set(byte_or);
  assign bpos     = $signed({c_q, k_sel});
  assign x1_ext   = $signed({2'b00, x1_q});
  assign x2_ext   = $signed({2'b00, x2_q});
  assign v_ext    = $signed({{3{v_q[7]}}, v_q});
  assign bpos_in  = (bpos >= lo_q) && (bpos <= hi_q);
  assign rear     = dn_q ? (bpos > half_q) : (bpos < half_q);
  assign front    = dn_q ? (bpos - x1_ext + 11'sd1) : (bpos - x2_ext - 11'sd1);
  assign mv_raw   = rear ? v_ext : front;
  assign mv_sat   = (mv_raw > 11'sd127)  ? 8'sd127 :
                    (mv_raw < -11'sd128) ? -8'sd128 : mv_raw[7:0];
  assign mask     = span_mask(c_q[5:0], x1_q, x2_q);
  assign y_hit    = |(byte_or & mask);
  assign step     = v_q[7] ? -10'sd1 : 10'sd1;
  assign y_move   = j_q - $signed({2'b00, r_q}) - step;
  assign tgt_byte = (op_q == OP_CLR_SCR) ? scr_rdata : obj_rdata;

  // Set-up values taken from the incoming beat
  logic signed [10:0] in_v_ext, in_x1_ext, in_x2_ext, in_hi_up, in_lo_dn, in_diff;
  logic signed [9:0]  in_r_ext, in_v10, in_step;
  logic               in_vneg, in_vzero, in_fire;
  op_e                in_op;

  assign in_op     = op_e'(in_i.operation);
  assign in_vneg   = in_i.velocity[7];
  assign in_vzero  = (in_i.velocity == 8'sd0);
  assign in_v_ext  = $signed({{3{in_i.velocity[7]}}, in_i.velocity});
  assign in_x1_ext = $signed({2'b00, in_i.span_left});
  assign in_x2_ext = $signed({2'b00, in_i.span_right});
  assign in_hi_up  = in_x2_ext + in_v_ext;
  assign in_lo_dn  = in_x1_ext + in_v_ext;
  assign in_diff   = in_x2_ext - in_x1_ext;
  assign in_r_ext  = $signed({2'b00, in_i.row});
  assign in_v10    = $signed({{2{in_i.velocity[7]}}, in_i.velocity});
  assign in_step   = in_vneg ? -10'sd1 : 10'sd1;
  assign in_fire   = in_i.valid && in_i.ready;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.allowed_move = out_move_q;
  assign out_o.pixel_set    = out_pix_q;
  assign out_o.read_value   = out_rd_q;

  logic do_advance, do_row_done, do_finish;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    x1_d       = x1_q;
    x2_d       = x2_q;
    r_d        = r_q;
    v_d        = v_q;
    addr_d     = addr_q;
    data_d     = data_q;
    sel_d      = sel_q;
    dn_d       = dn_q;
    c_d        = c_q;
    c_start_d  = c_start_q;
    c_end_d    = c_end_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    half_d     = half_q;
    j_d        = j_q;
    jend_d     = jend_q;
    row_base_d = row_base_q;
    row_ok_d   = row_ok_q;
    ok_d       = ok_q;
    wr_data_d  = wr_data_q;
    res_move_d = res_move_q;
    res_pix_d  = res_pix_q;
    res_rd_d   = res_rd_q;
    out_move_d = out_move_q;
    out_pix_d  = out_pix_q;
    out_rd_d   = out_rd_q;
    out_valid_d = out_valid_q;
    clr_d      = clr_q;
    scr_we     = 1'b0;
    obj_we     = 1'b0;
    ram_waddr  = col_addr;
    ram_wdata  = wr_data_q;
    do_advance  = 1'b0;
    do_row_done = 1'b0;
    do_finish   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        scr_we    = 1'b1;
        obj_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MAP_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_d       = in_op;
          x1_d       = in_i.span_left;
          x2_d       = in_i.span_right;
          r_d        = in_i.row;
          v_d        = in_i.velocity;
          addr_d     = in_i.byte_address;
          data_d     = in_i.byte_data;
          sel_d      = in_i.map_select;
          dn_d       = (in_op == OP_CLIP_X) && in_vneg;
          res_move_d = '0;
          res_pix_d  = 1'b0;
          res_rd_d   = '0;
          lo_d       = (in_vneg) ? in_lo_dn : in_x1_ext;
          hi_d       = (in_vneg) ? in_x2_ext : in_hi_up;
          half_d     = in_x1_ext + $signed({in_diff[10], in_diff[10:1]});
          jend_d     = in_r_ext + in_v10;
          j_d        = (in_op == OP_CLIP_Y) ? (in_r_ext + in_step) : in_r_ext;
          c_start_d  = ((in_op == OP_CLIP_X) && in_vneg) ?
                       $signed({2'b00, in_i.span_right[8:3]}) :
                       $signed({2'b00, in_i.span_left[8:3]});
          if (in_op == OP_TEST) begin
            c_end_d = $signed({2'b00, in_i.span_left[8:3]});
          end else if (in_op == OP_CLIP_X) begin
            c_end_d = in_vneg ? in_lo_dn[10:3] : in_hi_up[10:3];
          end else begin
            c_end_d = $signed({2'b00, in_i.span_right[8:3]});
          end
          priority if (in_op == OP_LOAD) begin
            state_d = ST_LOAD;
          end else if (in_op == OP_READ) begin
            state_d = ST_BREAD;
          end else if ((in_op == OP_CLIP_X || in_op == OP_CLIP_Y) && in_vzero) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_ROW;
          end
        end
      end
      ST_LOAD: begin
        scr_we    = addr_ok;
        ram_waddr = byte_raddr;
        ram_wdata = data_q;
        state_d   = ST_FIN;
      end
      ST_BREAD: begin
        ok_d    = addr_ok;
        state_d = ST_BYTE;
      end
      ST_BYTE: begin
        res_rd_d = ok_q ? (sel_q ? obj_rdata : scr_rdata) : '0;
        state_d  = ST_FIN;
      end
      ST_ROW: begin
        row_base_d = row_prod[AW-1:0];
        row_ok_d   = row_ok;
        c_d        = c_start_q;
        if (!row_ok || (dn_q ? (c_start_q < c_end_q) : (c_start_q > c_end_q))) begin
          do_row_done = 1'b1;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        ok_d    = cell_ok;
        state_d = ST_EV;
      end
      ST_EV: begin
        unique case (op_q)
          OP_TEST: begin
            res_pix_d = ok_q && scr_rdata[~x1_q[2:0]];
            do_finish = 1'b1;
          end
          OP_SET_OBJ, OP_CLR_OBJ, OP_CLR_SCR: begin
            wr_data_d = (op_q == OP_SET_OBJ) ? (tgt_byte | mask) : (tgt_byte & ~mask);
            if (ok_q) begin
              state_d = ST_WR;
            end else begin
              do_advance = 1'b1;
            end
          end
          OP_CLIP_X: begin
            if ((byte_or != '0) && bpos_in) begin
              res_move_d = mv_sat;
              do_finish  = 1'b1;
            end else begin
              do_advance = 1'b1;
            end
          end
          OP_CLIP_Y: begin
            if (y_hit) begin
              res_move_d = y_move[7:0];
              do_finish  = 1'b1;
            end else begin
              do_advance = 1'b1;
            end
          end
          default: begin
            do_finish = 1'b1;
          end
        endcase
      end
      ST_WR: begin
        scr_we     = (op_q == OP_CLR_SCR);
        obj_we     = (op_q != OP_CLR_SCR);
        do_advance = 1'b1;
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_move_d  = res_move_q;
          out_pix_d   = res_pix_q;
          out_rd_d    = res_rd_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_advance) begin
      if (c_q == c_end_q) begin
        do_row_done = 1'b1;
      end else begin
        c_d     = dn_q ? (c_q - 8'sd1) : (c_q + 8'sd1);
        state_d = ST_RD;
      end
    end

    // A row without a hit: clip y moves on until the last requested row and
    // then, like clip x, reports the full velocity; span edits are complete.
    if (do_row_done) begin
      if (op_q == OP_CLIP_Y && j_q != jend_q) begin
        j_d     = j_q + step;
        state_d = ST_ROW;
      end else begin
        if (op_q == OP_CLIP_X || op_q == OP_CLIP_Y) begin
          res_move_d = v_q;
        end
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      state_d = ST_FIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    x1_q       <= x1_d;
    x2_q       <= x2_d;
    r_q        <= r_d;
    v_q        <= v_d;
    addr_q     <= addr_d;
    data_q     <= data_d;
    sel_q      <= sel_d;
    dn_q       <= dn_d;
    c_q        <= c_d;
    c_start_q  <= c_start_d;
    c_end_q    <= c_end_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    half_q     <= half_d;
    j_q        <= j_d;
    jend_q     <= jend_d;
    row_base_q <= row_base_d;
    row_ok_q   <= row_ok_d;
    ok_q       <= ok_d;
    wr_data_q  <= wr_data_d;
    res_move_q <= res_move_d;
    res_pix_q  <= res_pix_d;
    res_rd_q   <= res_rd_d;
    out_move_q <= out_move_d;
    out_pix_q  <= out_pix_d;
    out_rd_q   <= out_rd_d;
  end

  // The maps are never written while the sequencer waits for a beat.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(scr_we || obj_we))
    else $error("map written while idle");

  // Every write lands inside the map.
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scr_we || obj_we) |-> (CALC_W'(ram_waddr) < CALC_W'(MAP_BYTES)))
    else $error("map write address out of range");

  // A column judged to lie on the map is read from inside it.
  a_raddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && cell_ok) |-> (CALC_W'(col_addr) < CALC_W'(MAP_BYTES)))
    else $error("column read address out of range");

  // Leaving the finish state always presents a result.
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && state_d == ST_IDLE) |=> out_valid_q)
    else $error("result lost on completion");

endmodule

`default_nettype wire

@@ tb/sv/tb_collision_bitmap_clip_engine.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_collision_bitmap_clip_engine: self-checking bench for the clip engine
// Mirrors both boundary bitmaps, predicts the result of every accepted beat
// and compares each output beat field by field. A short directed sequence
// is followed by random traffic concentrated on a band of rows, with random
// idling on both channels, a long output stall and two drain pauses.
// ============================================================================
`default_nettype none

module tb_collision_bitmap_clip_engine;
  import cbce_pkg::*;

  localparam int LINE_BYTES    = 40;
  localparam int ROWS          = 200;
  localparam int MAP_BYTES     = LINE_BYTES * ROWS;
  localparam int BYTE_PIX      = 8;
  localparam int X_MAX         = (1 << X_W) - 1;
  localparam int ADDR_MAX      = (1 << ADDR_W) - 1;
  localparam int HOT_ROW       = 90;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int CALM_TAIL     = 150;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_LEN      = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_PRINTS    = 40;

  typedef struct {
    bit                      drain;  // pause marker: no beat, wait for results
    op_e                     op;
    logic [X_W-1:0]          left;
    logic [X_W-1:0]          right;
    logic [ROW_W-1:0]        row;
    logic signed [VEL_W-1:0] vel;
    logic [ADDR_W-1:0]       addr;
    logic [BYTE_W-1:0]       data;
    logic                    sel;
  } request_t;

  typedef struct {
    logic signed [VEL_W-1:0] move;
    logic                    pix;
    logic [BYTE_W-1:0]       rd;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cbce_in_if  in_bus ();
  cbce_out_if out_bus ();

  collision_bitmap_clip_engine #(
    .LINE_BYTES (LINE_BYTES),
    .ROWS       (ROWS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [BYTE_W-1:0] screen_mirror [MAP_BYTES];
  logic [BYTE_W-1:0] object_mirror [MAP_BYTES];

  request_t requests_to_send [$];
  outcome_t awaited_results [$];
  request_t live_req;

  int  total_items = 0;
  int  beats_in    = 0;
  int  beats_out   = 0;
  int  errors      = 0;
  int  pauses      = 0;
  int  op_seen [8];
  int  send_gap    = 0;
  int  recv_gap    = 0;
  int  hold_left   = 0;
  bit  held        = 1'b0;
  bit  paused      = 1'b0;

  // --------------------------------------------------------------------------
  // Bitmap mirror and result prediction
  // --------------------------------------------------------------------------
  function automatic bit in_map(int r, int c);
    return r >= 0 && r < ROWS && c >= 0 && c < LINE_BYTES;
  endfunction

  function automatic logic [BYTE_W-1:0] merged_byte(int r, int c);
    if (!in_map(r, c)) return '0;
    return screen_mirror[r * LINE_BYTES + c] | object_mirror[r * LINE_BYTES + c];
  endfunction

  // Pixels x1..x2 within column c; a span inside one byte gets both end masks.
  function automatic logic [BYTE_W-1:0] cover_mask(int c, int x1, int x2);
    logic [BYTE_W-1:0] m;
    m = 8'hff;
    if (c == x2 / BYTE_PIX) m = m & (8'hff << (c * BYTE_PIX + 7 - x2));
    if (c == x1 / BYTE_PIX) m = m & (8'hff >> (x1 - c * BYTE_PIX));
    return m;
  endfunction

  function automatic void edit_span(bit on_object, bit set_bits, int x1, int x2, int r);
    int k;
    logic [BYTE_W-1:0] m;
    for (int c = x1 / BYTE_PIX; c <= x2 / BYTE_PIX; c++) begin
      if (in_map(r, c)) begin
        k = r * LINE_BYTES + c;
        m = cover_mask(c, x1, x2);
        if (on_object && set_bits) object_mirror[k] = object_mirror[k] | m;
        else if (on_object)        object_mirror[k] = object_mirror[k] & ~m;
        else                       screen_mirror[k] = screen_mirror[k] & ~m;
      end
    end
  endfunction

  function automatic int lead_pixel(logic [BYTE_W-1:0] v);
    for (int k = 0; k < BYTE_PIX; k++) if (v[7 - k]) return k;
    return BYTE_PIX;
  endfunction

  function automatic int trail_pixel(logic [BYTE_W-1:0] v);
    for (int k = BYTE_PIX - 1; k >= 0; k--) if (v[7 - k]) return k;
    return BYTE_PIX;
  endfunction

  // Only the nearest set bit of each byte counts; an out-of-range one does not
  // stop the scan.
  function automatic int horizontal_clip(int x1, int x2, int v, int r);
    int b;
    int half;
    half = x1 + ((x2 - x1) >>> 1);
    if (v == 0) return 0;
    if (v > 0) begin
      for (int c = x1 / BYTE_PIX; c <= ((x2 + v) >>> 3); c++) begin
        b = lead_pixel(merged_byte(r, c));
        if (b < BYTE_PIX) begin
          b += c * BYTE_PIX;
          if (b >= x1 && b <= x2 + v) return (b < half) ? v : b - x2 - 1;
        end
      end
    end else begin
      for (int c = x2 / BYTE_PIX; c >= ((x1 + v) >>> 3); c--) begin
        b = trail_pixel(merged_byte(r, c));
        if (b < BYTE_PIX) begin
          b += c * BYTE_PIX;
          if (b >= x1 + v && b <= x2) return (b > half) ? v : b - x1 + 1;
        end
      end
    end
    return v;
  endfunction

  function automatic int vertical_clip(int x1, int x2, int v, int r);
    int s;
    if (v == 0) return 0;
    s = (v > 0) ? 1 : -1;
    for (int j = r + s; j != r + v + s; j += s) begin
      for (int c = x1 / BYTE_PIX; c <= x2 / BYTE_PIX; c++) begin
        if ((merged_byte(j, c) & cover_mask(c, x1, x2)) != '0) return j - r - s;
      end
    end
    return v;
  endfunction

  function automatic outcome_t bitmap_outcome(request_t q);
    outcome_t o;
    int x1, x2, r, v, mv;
    x1 = int'(q.left);
    x2 = int'(q.right);
    r  = int'(q.row);
    v  = int'(q.vel);
    o.move = '0;
    o.pix  = 1'b0;
    o.rd   = '0;
    case (q.op)
      OP_LOAD:    if (q.addr < MAP_BYTES) screen_mirror[q.addr] = q.data;
      OP_SET_OBJ: edit_span(1'b1, 1'b1, x1, x2, r);
      OP_CLR_OBJ: edit_span(1'b1, 1'b0, x1, x2, r);
      OP_CLR_SCR: edit_span(1'b0, 1'b0, x1, x2, r);
      OP_TEST: begin
        if (in_map(r, x1 / BYTE_PIX))
          o.pix = screen_mirror[r * LINE_BYTES + x1 / BYTE_PIX][7 - x1 % BYTE_PIX];
      end
      OP_CLIP_X: begin
        mv = horizontal_clip(x1, x2, v, r);
        if (mv > 127)  mv = 127;
        if (mv < -128) mv = -128;
        o.move = VEL_W'(mv);
      end
      OP_CLIP_Y: o.move = VEL_W'(vertical_clip(x1, x2, v, r));
      default: begin
        if (q.addr < MAP_BYTES) o.rd = q.sel ? object_mirror[q.addr] : screen_mirror[q.addr];
      end
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_request(op_e op, int l, int r, int rw, int v, int a, int d, bit s);
    request_t q;
    q.drain = 1'b0;
    q.op    = op;
    q.left  = X_W'(l);
    q.right = X_W'(r);
    q.row   = ROW_W'(rw);
    q.vel   = VEL_W'(v);
    q.addr  = ADDR_W'(a);
    q.data  = BYTE_W'(d);
    q.sel   = s;
    requests_to_send.push_back(q);
    total_items++;
  endtask

  task automatic add_drain();
    request_t q;
    q.drain = 1'b1;
    requests_to_send.push_back(q);
  endtask

  function automatic int pick_row();
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return HOT_ROW + $urandom_range(0, 15);
    if (p < 95) return $urandom_range(0, ROWS - 1);
    return $urandom_range(ROWS, (1 << ROW_W) - 1);
  endfunction

  function automatic int pick_x();
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, LINE_BYTES * BYTE_PIX - 1);
    return $urandom_range(LINE_BYTES * BYTE_PIX, X_MAX);
  endfunction

  function automatic int pick_address();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70)
      return (HOT_ROW + $urandom_range(0, 15)) * LINE_BYTES + $urandom_range(0, LINE_BYTES - 1);
    if (p < 95) return $urandom_range(0, MAP_BYTES - 1);
    return $urandom_range(MAP_BYTES, ADDR_MAX);
  endfunction

  // Every field is random; the ones the operation uses are then shaped so
  // that spans and clips land on the densely written band of rows.
  function automatic request_t random_request();
    request_t q;
    int pick, lo, hi;
    q.drain = 1'b0;
    q.left  = X_W'($urandom);
    q.right = X_W'($urandom);
    q.row   = ROW_W'($urandom);
    q.vel   = VEL_W'($urandom);
    q.addr  = ADDR_W'($urandom);
    q.data  = BYTE_W'($urandom);
    q.sel   = 1'($urandom);
    pick = $urandom_range(0, 99);
    if      (pick < 12) q.op = OP_LOAD;
    else if (pick < 27) q.op = OP_SET_OBJ;
    else if (pick < 35) q.op = OP_CLR_OBJ;
    else if (pick < 43) q.op = OP_CLR_SCR;
    else if (pick < 55) q.op = OP_TEST;
    else if (pick < 73) q.op = OP_CLIP_X;
    else if (pick < 87) q.op = OP_CLIP_Y;
    else                q.op = OP_READ;
    case (q.op)
      OP_LOAD, OP_READ: q.addr = ADDR_W'(pick_address());
      OP_TEST: begin
        q.left = X_W'(pick_x());
        q.row  = ROW_W'(pick_row());
      end
      default: begin
        q.row = ROW_W'(pick_row());
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          lo = pick_x();
          hi = lo + $urandom_range(0, 23);
          if (hi > X_MAX) hi = X_MAX;
        end else if (pick < 92) begin
          lo = pick_x();
          hi = pick_x();
        end else begin
          lo = $urandom_range(0, 7);
          hi = $urandom_range(LINE_BYTES * BYTE_PIX - 20, LINE_BYTES * BYTE_PIX - 1);
        end
        q.left  = X_W'(lo);
        q.right = X_W'(hi);
        if ($urandom_range(0, 2) == 0) q.vel = VEL_W'(int'($urandom_range(0, 16)) - 8);
        // Wide vertical scans are slow, so they only look a few rows away.
        if (q.op == OP_CLIP_Y && hi - lo > 64)
          q.vel = VEL_W'(int'($urandom_range(0, 32)) - 16);
      end
    endcase
    return q;
  endfunction

  task automatic log_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued requests, predicts each accepted beat
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit offer;
    offer = 1'b0;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        awaited_results.push_back(bitmap_outcome(live_req));
        op_seen[live_req.op]++;
        beats_in++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (paused) begin
          paused = (awaited_results.size() != 0);
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (requests_to_send.size() != 0) begin
          if (requests_to_send[0].drain) begin
            void'(requests_to_send.pop_front());
            paused = 1'b1;
            pauses++;
          end else if (requests_to_send.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 12);
          end else begin
            live_req = requests_to_send.pop_front();
            offer = 1'b1;
          end
        end
        in_bus.valid <= offer;
        if (offer) begin
          in_bus.operation    <= live_req.op;
          in_bus.span_left    <= live_req.left;
          in_bus.span_right   <= live_req.right;
          in_bus.row          <= live_req.row;
          in_bus.velocity     <= live_req.vel;
          in_bus.byte_address <= live_req.addr;
          in_bus.byte_data    <= live_req.data;
          in_bus.map_select   <= live_req.sel;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks result beats and paces the output ready
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    outcome_t want;
    bit take;
    take = 1'b0;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        beats_out++;
        if (awaited_results.size() == 0) begin
          log_mismatch($sformatf("result beat %0d arrived with nothing expected", beats_out));
        end else begin
          want = awaited_results.pop_front();
          if (out_bus.allowed_move !== want.move)
            log_mismatch($sformatf("beat %0d allowed_move %0d, expected %0d",
                                   beats_out, out_bus.allowed_move, want.move));
          if (out_bus.pixel_set !== want.pix)
            log_mismatch($sformatf("beat %0d pixel_set %0b, expected %0b",
                                   beats_out, out_bus.pixel_set, want.pix));
          if (out_bus.read_value !== want.rd)
            log_mismatch($sformatf("beat %0d read_value %02h, expected %02h",
                                   beats_out, out_bus.read_value, want.rd));
        end
      end
      // One long stall so that the result register fills and input backs up.
      if (!held && beats_out >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else if (requests_to_send.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 12);
      end else begin
        take = 1'b1;
      end
      out_bus.ready <= take;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence control
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.operation     = '0;
    in_bus.span_left     = '0;
    in_bus.span_right    = '0;
    in_bus.row           = '0;
    in_bus.velocity      = '0;
    in_bus.byte_address  = '0;
    in_bus.byte_data     = '0;
    in_bus.map_select    = 1'b0;
    out_bus.ready        = 1'b0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (screen_mirror[i]) begin
      screen_mirror[i] = '0;
      object_mirror[i] = '0;
    end

    // Directed: cleared maps, map corners, ignored addresses, span edges,
    // spans in one byte, reversed spans, off-map rows and columns, pixel
    // tests, zero velocity and extreme velocity clips.
    add_request(OP_READ,    0,   0,   0,    0, 0,        0,     1'b0);
    add_request(OP_READ,    0,   0,   0,    0, MAP_BYTES - 1, 0, 1'b1);
    add_request(OP_LOAD,    0,   0,   0,    0, 0,        8'hff, 1'b0);
    add_request(OP_LOAD,    0,   0,   0,    0, MAP_BYTES - 1, 8'h81, 1'b0);
    add_request(OP_LOAD,    0,   0,   0,    0, ADDR_MAX, 8'h55, 1'b0);
    add_request(OP_READ,    0,   0,   0,    0, ADDR_MAX, 0,     1'b0);
    add_request(OP_READ,    0,   0,   0,    0, MAP_BYTES - 1, 0, 1'b0);
    add_request(OP_SET_OBJ, 10,  12,  5,    0, 0,        0,     1'b0);
    add_request(OP_SET_OBJ, 20,  18,  5,    0, 0,        0,     1'b0);
    add_request(OP_READ,    0,   0,   0,    0, 5 * LINE_BYTES + 1, 0, 1'b1);
    add_request(OP_SET_OBJ, 0,   319, 199,  0, 0,        0,     1'b0);
    add_request(OP_SET_OBJ, 300, X_MAX, 3,  0, 0,        0,     1'b0);
    add_request(OP_SET_OBJ, 0,   319, 255,  0, 0,        0,     1'b0);
    add_request(OP_CLR_SCR, 0,   3,   0,    0, 0,        0,     1'b0);
    add_request(OP_CLR_OBJ, 8,   15,  199,  0, 0,        0,     1'b0);
    add_request(OP_READ,    0,   0,   0,    0, 199 * LINE_BYTES + 1, 0, 1'b1);
    add_request(OP_TEST,    4,   0,   0,    0, 0,        0,     1'b0);
    add_request(OP_TEST,    0,   0,   0,    0, 0,        0,     1'b0);
    add_request(OP_TEST,    400, 0,   0,    0, 0,        0,     1'b0);
    add_request(OP_TEST,    7,   0,   255,  0, 0,        0,     1'b0);
    add_request(OP_SET_OBJ, 250, 250, 10,   0, 0,        0,     1'b0);
    add_request(OP_SET_OBJ, 150, 150, 11,   0, 0,        0,     1'b0);
    add_request(OP_CLIP_X,  0,   400, 10,   1, 0,        0,     1'b0);
    add_request(OP_CLIP_X,  0,   400, 11,  -1, 0,        0,     1'b0);
    add_request(OP_CLIP_X,  0,   3,   0,    0, 0,        0,     1'b0);
    add_request(OP_CLIP_X,  16,  20,  199, -128, 0,      0,     1'b0);
    add_request(OP_CLIP_Y,  10,  12,  0,  127, 0,        0,     1'b0);
    add_request(OP_CLIP_Y,  0,   319, 199, -128, 0,      0,     1'b0);
    add_request(OP_CLIP_Y,  0,   7,   255, -60, 0,       0,     1'b0);
    add_request(OP_CLIP_Y,  0,   7,   0,    0, 0,        0,     1'b0);
    add_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) add_drain();
      requests_to_send.push_back(random_request());
      total_items++;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beats_in != total_items) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d beats in, %0d results out, %0d drain pauses, output stall taken: %0b",
             beats_in, beats_out, pauses, held);
    $display("loads %0d, span edits %0d, pixel tests %0d, clip x %0d, clip y %0d, reads %0d",
             op_seen[OP_LOAD], op_seen[OP_SET_OBJ] + op_seen[OP_CLR_OBJ] + op_seen[OP_CLR_SCR],
             op_seen[OP_TEST], op_seen[OP_CLIP_X], op_seen[OP_CLIP_Y], op_seen[OP_READ]);
    if (errors == 0) begin
      $display("tb_collision_bitmap_clip_engine: clean");
    end else begin
      $display("tb_collision_bitmap_clip_engine: errors");
    end
    $finish;
  end

  // The timeout covers the clearing pass after reset and allows for many
  // times the slowest legitimate run.
  initial begin
    #200_000_000;
    $display("tb_collision_bitmap_clip_engine: errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/cbce_pkg.sv
sv/cbce_in_if.sv
sv/cbce_out_if.sv
sv/cbce_ram.sv
sv/collision_bitmap_clip_engine.sv
tb/sv/tb_collision_bitmap_clip_engine.sv
